[rtl/vvoa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vvoa_pkg: shared types and helpers of the voxel view-order address block
// Field widths, register indexes, axis order codes, queue and pipeline
// payload records, and the small functions used by front and back.
// ----------------------------------------------------------------------------
package vvoa_pkg;

  localparam int CAM_W      = 32;
  localparam int IDX_W      = 24;
  localparam int ADDR_W     = 24;
  localparam int LEN_W      = 9;
  localparam int AREA_W     = 17;
  localparam int CNT_W      = 25;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 25;

  localparam int MAX_EDGE_DEF = 256;
  localparam int QUEUE_DEPTH  = 4;

  // Register indexes of the write port
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FACE_AREA   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VOXEL_COUNT = 2'd2;

  localparam logic [LEN_W-1:0]  EDGE_LENGTH_RST = 9'd16;
  localparam logic [AREA_W-1:0] FACE_AREA_RST   = 17'd256;
  localparam logic [CNT_W-1:0]  VOXEL_COUNT_RST = 25'd4096;

  // Axis order: slice axis, row axis, unit axis
  typedef enum logic [2:0] {
    ORD_ZXY,
    ORD_ZYX,
    ORD_XZY,
    ORD_YZX,
    ORD_YXZ,
    ORD_XYZ
  } ord_e;

  typedef enum logic [1:0] {
    ROLE_UNIT,
    ROLE_ROW,
    ROLE_SLICE
  } role_e;

  typedef struct packed {
    role_e rx;
    role_e ry;
    role_e rz;
  } roles_t;

  // neg bits: [2] x, [1] y, [0] z
  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [LEN_W-1:0]  len;
    logic [AREA_W-1:0] area;
    logic [2:0]        neg;
    ord_e              ord;
    logic              oor;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [LEN_W-1:0] len;
    logic [2:0]       neg;
    ord_e             ord;
    logic             oor;
  } s1_t;

  typedef struct packed {
    logic [IDX_W-1:0]  slice;
    logic [AREA_W-1:0] rem_a;
    logic [AREA_W-1:0] area;
    logic [2:0]        neg;
    ord_e              ord;
    logic              oor;
  } s2_t;

  typedef struct packed {
    logic [IDX_W-1:0]  slice;
    logic [LEN_W-1:0]  unit;
    logic [AREA_W-1:0] area;
    logic [2:0]        neg;
    ord_e              ord;
    logic              oor;
  } s3_t;

  function automatic roles_t axis_roles(input ord_e ord);
    roles_t r;
    unique case (ord)
      ORD_ZXY: r = '{rx: ROLE_ROW,   ry: ROLE_UNIT,  rz: ROLE_SLICE};
      ORD_ZYX: r = '{rx: ROLE_UNIT,  ry: ROLE_ROW,   rz: ROLE_SLICE};
      ORD_XZY: r = '{rx: ROLE_SLICE, ry: ROLE_UNIT,  rz: ROLE_ROW};
      ORD_YZX: r = '{rx: ROLE_UNIT,  ry: ROLE_SLICE, rz: ROLE_ROW};
      ORD_YXZ: r = '{rx: ROLE_ROW,   ry: ROLE_SLICE, rz: ROLE_UNIT};
      ORD_XYZ: r = '{rx: ROLE_SLICE, ry: ROLE_ROW,   rz: ROLE_UNIT};
      default: r = '{rx: ROLE_SLICE, ry: ROLE_ROW,   rz: ROLE_UNIT};
    endcase
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] pick_count(input role_e role,
                                                  input logic [LEN_W-1:0] unit,
                                                  input logic [AREA_W-1:0] row,
                                                  input logic [IDX_W-1:0] slice);
    logic [IDX_W-1:0] k;
    case (role)
      ROLE_UNIT: k = IDX_W'(unit);
      ROLE_ROW:  k = IDX_W'(row);
      default:   k = slice;
    endcase
    return k;
  endfunction

  // Mirror a count along an axis that runs downward
  function automatic logic [ADDR_W-1:0] orient(input logic [IDX_W-1:0] k,
                                               input logic neg,
                                               input logic [LEN_W-1:0] len);
    logic [ADDR_W-1:0] v;
    v = neg ? (ADDR_W'(len) - ADDR_W'(1) - ADDR_W'(k)) : ADDR_W'(k);
    return v;
  endfunction

endpackage

[rtl/vvoa_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vvoa_req_if: request channel
// Camera position and draw index, valid/ready handshake.
// ----------------------------------------------------------------------------
interface vvoa_req_if;
  logic                                valid;
  logic                                ready;
  logic signed [vvoa_pkg::CAM_W-1:0]   cam_x;
  logic signed [vvoa_pkg::CAM_W-1:0]   cam_y;
  logic signed [vvoa_pkg::CAM_W-1:0]   cam_z;
  logic        [vvoa_pkg::IDX_W-1:0]   draw_index;

  modport source (output valid, cam_x, cam_y, cam_z, draw_index, input ready);
  modport sink   (input valid, cam_x, cam_y, cam_z, draw_index, output ready);
endinterface

[rtl/vvoa_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vvoa_rsp_if: response channel
// Voxel address and out-of-range flag, valid/ready handshake.
// ----------------------------------------------------------------------------
interface vvoa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [vvoa_pkg::ADDR_W-1:0]   voxel_address;
  logic                          index_out_of_range;

  modport source (output valid, voxel_address, index_out_of_range, input ready);
  modport sink   (input valid, voxel_address, index_out_of_range, output ready);
endinterface

[rtl/voxel_view_order_address.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_view_order_address: back-to-front voxel address generator
// Ranks camera axes, splits a draw index into unit/row/slice counts and
// packs the mirrored counts into a linear voxel address.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake          Payload
//  req_i    in   valid/ready        cam_x, cam_y, cam_z (Q16.16), draw_index
//  rsp_o    out  valid/ready        voxel_address, index_out_of_range
//  cfg      in   cfg_we_i, no wait  cfg_idx_i selects register, cfg_data_i
//
//  One transaction per cycle sustained while rsp_o takes responses; a request
//  passes the queue, 24 + 24 + 17 divider stages (bit-per-stage dividers for
//  face area and edge length) and three output stages before response valid.
//  A four-entry queue parts intake from the divider pipe; the pipe stalls as
//  a whole only while the output register holds an untaken transaction.
//  Reset restores the grid registers to a 16-voxel edge; no clearing pass.
//
module voxel_view_order_address #(
  parameter int MAX_EDGE = vvoa_pkg::MAX_EDGE_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  vvoa_req_if.sink                          req_i,
  vvoa_rsp_if.source                        rsp_o,
  input  logic                              cfg_we_i,
  input  logic [vvoa_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [vvoa_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  logic [vvoa_pkg::LEN_W-1:0]  edge_length_q;
  logic [vvoa_pkg::AREA_W-1:0] face_area_q;
  logic [vvoa_pkg::CNT_W-1:0]  voxel_count_q;

  logic            push, pop, full, empty;
  vvoa_pkg::item_t push_item, head_item;

  // Grid registers; writes beyond the register list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_length_q <= vvoa_pkg::EDGE_LENGTH_RST;
      face_area_q   <= vvoa_pkg::FACE_AREA_RST;
      voxel_count_q <= vvoa_pkg::VOXEL_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        vvoa_pkg::CFG_EDGE_LENGTH: edge_length_q <= cfg_data_i[vvoa_pkg::LEN_W-1:0];
        vvoa_pkg::CFG_FACE_AREA:   face_area_q   <= cfg_data_i[vvoa_pkg::AREA_W-1:0];
        vvoa_pkg::CFG_VOXEL_COUNT: voxel_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Classify each request and queue it
  vvoa_front #(.MAX_EDGE(MAX_EDGE)) u_front (
    .req_i         (req_i),
    .edge_length_i (edge_length_q),
    .face_area_i   (face_area_q),
    .voxel_count_i (voxel_count_q),
    .full_i        (full),
    .push_o        (push),
    .item_o        (push_item)
  );

  vvoa_queue #(.DEPTH(vvoa_pkg::QUEUE_DEPTH)) u_queue (
    .clk_i, .rst_ni,
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .item_o  (head_item)
  );

  // Split the index and pack the address
  vvoa_back u_back (
    .clk_i, .rst_ni,
    .empty_i (empty),
    .item_i  (head_item),
    .pop_o   (pop),
    .rsp_o   (rsp_o)
  );

endmodule

[rtl/vvoa_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vvoa_front: request intake and classification
// Ranks the camera magnitudes, clamps the grid registers, flags the index.
// ----------------------------------------------------------------------------
module vvoa_front #(
  parameter int MAX_EDGE = vvoa_pkg::MAX_EDGE_DEF
) (
  vvoa_req_if.sink                      req_i,
  input  logic [vvoa_pkg::LEN_W-1:0]    edge_length_i,
  input  logic [vvoa_pkg::AREA_W-1:0]   face_area_i,
  input  logic [vvoa_pkg::CNT_W-1:0]    voxel_count_i,
  input  logic                          full_i,
  output logic                          push_o,
  output vvoa_pkg::item_t               item_o
);

  localparam int AreaMax = MAX_EDGE * MAX_EDGE;

  logic [vvoa_pkg::CAM_W-1:0]  ax, ay, az;
  logic [vvoa_pkg::LEN_W-1:0]  len_nz;
  logic [vvoa_pkg::AREA_W-1:0] area_nz;
  vvoa_pkg::ord_e              ord;

  assign req_i.ready = !full_i;
  assign push_o      = req_i.valid && !full_i;

  assign ax = req_i.cam_x[31] ? (~req_i.cam_x + 32'd1) : req_i.cam_x;
  assign ay = req_i.cam_y[31] ? (~req_i.cam_y + 32'd1) : req_i.cam_y;
  assign az = req_i.cam_z[31] ? (~req_i.cam_z + 32'd1) : req_i.cam_z;

  always_comb begin
    if (az > ay) begin
      if (az > ax) begin
        ord = (ax > ay) ? vvoa_pkg::ORD_ZXY : vvoa_pkg::ORD_ZYX;
      end else begin
        ord = vvoa_pkg::ORD_XZY;
      end
    end else begin
      if (ay > ax) begin
        ord = (az > ax) ? vvoa_pkg::ORD_YZX : vvoa_pkg::ORD_YXZ;
      end else begin
        ord = vvoa_pkg::ORD_XYZ;
      end
    end
  end

  // Treat zero as one, clamp to the largest grid
  always_comb begin
    len_nz  = (edge_length_i == '0) ? vvoa_pkg::LEN_W'(1) : edge_length_i;
    area_nz = (face_area_i == '0) ? vvoa_pkg::AREA_W'(1) : face_area_i;
    if (32'(len_nz) > MAX_EDGE) begin
      len_nz = vvoa_pkg::LEN_W'(MAX_EDGE);
    end
    if (32'(area_nz) > AreaMax) begin
      area_nz = vvoa_pkg::AREA_W'(AreaMax);
    end
  end

  always_comb begin
    item_o.idx  = req_i.draw_index;
    item_o.len  = len_nz;
    item_o.area = area_nz;
    item_o.neg  = {req_i.cam_x[31], req_i.cam_y[31], req_i.cam_z[31]};
    item_o.ord  = ord;
    item_o.oor  = vvoa_pkg::CNT_W'(req_i.draw_index) >= voxel_count_i;
  end

endmodule

[rtl/vvoa_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vvoa_queue: short queue between front and back
// Register-based FIFO of classified items.
// ----------------------------------------------------------------------------
module vvoa_queue #(
  parameter int DEPTH = vvoa_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  vvoa_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output vvoa_pkg::item_t item_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  vvoa_pkg::item_t       mem_q [DEPTH];
  logic [PtrW-1:0]       wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]       cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

[rtl/vvoa_div_pipe.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vvoa_div_pipe: pipelined restoring divider
// One quotient bit per stage, sideband carried alongside, global stall.
// ----------------------------------------------------------------------------
module vvoa_div_pipe #(
  parameter int N  = 24,
  parameter int D  = 17,
  parameter int SB = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [N-1:0]  dividend_i,
  input  logic [D-1:0]  divisor_i,
  input  logic [SB-1:0] side_i,
  output logic          valid_o,
  output logic [N-1:0]  quot_o,
  output logic [D-1:0]  rem_o,
  output logic [D-1:0]  divisor_o,
  output logic [SB-1:0] side_o
);

  logic          valid_q [N];
  logic [N-1:0]  work_q  [N];
  logic [D-1:0]  rem_q   [N];
  logic [D-1:0]  div_q   [N];
  logic [SB-1:0] side_q  [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic          v_in;
    logic [N-1:0]  w_in;
    logic [D-1:0]  r_in, d_in;
    logic [SB-1:0] s_in;
    logic [D:0]    shifted, diff;
    logic          ge;

    if (i == 0) begin : g_first
      assign v_in = valid_i;
      assign w_in = dividend_i;
      assign r_in = '0;
      assign d_in = divisor_i;
      assign s_in = side_i;
    end else begin : g_next
      assign v_in = valid_q[i-1];
      assign w_in = work_q[i-1];
      assign r_in = rem_q[i-1];
      assign d_in = div_q[i-1];
      assign s_in = side_q[i-1];
    end

    // Bring down the next dividend bit, subtract when it fits
    assign shifted = {r_in, w_in[N-1]};
    assign diff    = shifted - {1'b0, d_in};
    assign ge      = shifted >= {1'b0, d_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else if (en_i) begin
        valid_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        work_q[i] <= {w_in[N-2:0], ge};
        rem_q[i]  <= ge ? diff[D-1:0] : shifted[D-1:0];
        div_q[i]  <= d_in;
        side_q[i] <= s_in;
      end
    end
  end

  assign valid_o   = valid_q[N-1];
  assign quot_o    = work_q[N-1];
  assign rem_o     = rem_q[N-1];
  assign divisor_o = div_q[N-1];
  assign side_o    = side_q[N-1];

endmodule

[rtl/vvoa_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vvoa_back: count split and address packing
// Three divider pipes, axis mapping, products and the output register.
// ----------------------------------------------------------------------------
module vvoa_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  vvoa_pkg::item_t item_i,
  output logic            pop_o,
  vvoa_rsp_if.source      rsp_o
);

  localparam int IdxW  = vvoa_pkg::IDX_W;
  localparam int LenW  = vvoa_pkg::LEN_W;
  localparam int AreaW = vvoa_pkg::AREA_W;
  localparam int AddrW = vvoa_pkg::ADDR_W;

  logic en;

  vvoa_pkg::s1_t s1_in, s1_out;
  vvoa_pkg::s2_t s2_in, s2_out;
  vvoa_pkg::s3_t s3_in, s3_out;

  logic             d1_valid, d2_valid, d3_valid;
  logic [IdxW-1:0]  d1_quot;
  logic [AreaW-1:0] d1_rem, d1_div;
  logic [LenW-1:0]  d2_rem, d2_div, d3_div;
  logic [AreaW-1:0] d3_quot;

  vvoa_pkg::roles_t roles;

  logic             m1_valid_q, m2_valid_q, out_valid_q;
  logic [AddrW-1:0] x_q, y_q, z_q, x2_q, za_q, yl_q, addr_q;
  logic [AreaW-1:0] area_q;
  logic [LenW-1:0]  len_q;
  logic             oor1_q, oor2_q, oor_q;
  logic [AddrW+AreaW-1:0] za_full;
  logic [AddrW+LenW-1:0]  yl_full;

  // Advance the whole pipe unless the output holds an untaken transaction
  assign en    = !out_valid_q || rsp_o.ready;
  assign pop_o = en && !empty_i;

  assign s1_in = '{idx: item_i.idx, len: item_i.len, neg: item_i.neg,
                   ord: item_i.ord, oor: item_i.oor};

  vvoa_div_pipe #(.N(IdxW), .D(AreaW), .SB($bits(vvoa_pkg::s1_t))) u_div_area (
    .clk_i, .rst_ni, .en_i(en), .valid_i(pop_o),
    .dividend_i(item_i.idx), .divisor_i(item_i.area), .side_i(s1_in),
    .valid_o(d1_valid), .quot_o(d1_quot), .rem_o(d1_rem), .divisor_o(d1_div),
    .side_o(s1_out)
  );

  assign s2_in = '{slice: d1_quot, rem_a: d1_rem, area: d1_div, neg: s1_out.neg,
                   ord: s1_out.ord, oor: s1_out.oor};

  vvoa_div_pipe #(.N(IdxW), .D(LenW), .SB($bits(vvoa_pkg::s2_t))) u_div_unit (
    .clk_i, .rst_ni, .en_i(en), .valid_i(d1_valid),
    .dividend_i(s1_out.idx), .divisor_i(s1_out.len), .side_i(s2_in),
    .valid_o(d2_valid), .quot_o(), .rem_o(d2_rem), .divisor_o(d2_div),
    .side_o(s2_out)
  );

  assign s3_in = '{slice: s2_out.slice, unit: d2_rem, area: s2_out.area,
                   neg: s2_out.neg, ord: s2_out.ord, oor: s2_out.oor};

  vvoa_div_pipe #(.N(AreaW), .D(LenW), .SB($bits(vvoa_pkg::s3_t))) u_div_row (
    .clk_i, .rst_ni, .en_i(en), .valid_i(d2_valid),
    .dividend_i(s2_out.rem_a), .divisor_i(d2_div), .side_i(s3_in),
    .valid_o(d3_valid), .quot_o(d3_quot), .rem_o(), .divisor_o(d3_div),
    .side_o(s3_out)
  );

  assign roles   = vvoa_pkg::axis_roles(s3_out.ord);
  assign za_full = z_q * area_q;
  assign yl_full = y_q * len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_valid_q  <= 1'b0;
      m2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      m1_valid_q  <= d3_valid;
      m2_valid_q  <= m1_valid_q;
      out_valid_q <= m2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // Map counts onto axes and mirror negative ones
      x_q    <= vvoa_pkg::orient(vvoa_pkg::pick_count(roles.rx, s3_out.unit, d3_quot,
                                 s3_out.slice), s3_out.neg[2], d3_div);
      y_q    <= vvoa_pkg::orient(vvoa_pkg::pick_count(roles.ry, s3_out.unit, d3_quot,
                                 s3_out.slice), s3_out.neg[1], d3_div);
      z_q    <= vvoa_pkg::orient(vvoa_pkg::pick_count(roles.rz, s3_out.unit, d3_quot,
                                 s3_out.slice), s3_out.neg[0], d3_div);
      area_q <= s3_out.area;
      len_q  <= d3_div;
      oor1_q <= s3_out.oor;
      za_q   <= za_full[AddrW-1:0];
      yl_q   <= yl_full[AddrW-1:0];
      x2_q   <= x_q;
      oor2_q <= oor1_q;
      addr_q <= oor2_q ? '0 : (za_q + yl_q + x2_q);
      oor_q  <= oor2_q;
    end
  end

  assign rsp_o.valid              = out_valid_q;
  assign rsp_o.voxel_address      = addr_q;
  assign rsp_o.index_out_of_range = oor_q;

`ifndef ASSERT_OFF
  a_area_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d1_valid |-> d1_rem < d1_div)
    else $error("slice remainder not below face area");

  a_unit_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d3_valid |-> s3_out.unit < d3_div)
    else $error("unit count not below edge length");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(m1_valid_q) && $stable(m2_valid_q))
    else $error("pipe advanced while output stalled");
`endif

endmodule
